### hdl/bwpt_pkg.sv
// ============================================================================
// bwpt_pkg
// Shared types, constants and helper functions of the body-to-world point
// transform: payload structs, register indexes, matrix term recipes and the
// sine table generator used at elaboration.
// ============================================================================
`default_nettype none

package bwpt_pkg;

    localparam int COORD_W    = 20;
    localparam int TRIG_BITS  = 10;
    localparam int ANGLE_W    = 16;
    localparam int OFFSET_W   = 32;
    localparam int WORLD_W    = 32;
    localparam int TERM_W     = 18;
    localparam int FACT_W     = 19;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROLL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_YAW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EAST  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NORTH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_UP    = 3'd5;

    // Factor codes of the matrix term recipes
    localparam logic [2:0] F_SR   = 3'd0;
    localparam logic [2:0] F_CR   = 3'd1;
    localparam logic [2:0] F_SP   = 3'd2;
    localparam logic [2:0] F_CP   = 3'd3;
    localparam logic [2:0] F_SY   = 3'd4;
    localparam logic [2:0] F_CY   = 3'd5;
    localparam logic [2:0] F_ONE  = 3'd6;
    localparam logic [2:0] F_ZERO = 3'd7;

    localparam logic signed [TERM_W-1:0] Q17_MAX = 18'sd131071;
    localparam logic signed [TERM_W-1:0] Q17_MIN = -18'sd131072;

    typedef struct packed {
        logic signed [COORD_W-1:0] body_x;
        logic signed [COORD_W-1:0] body_y;
        logic signed [COORD_W-1:0] body_z;
    } point_t;

    typedef struct packed {
        logic signed [WORLD_W-1:0] world_east;
        logic signed [WORLD_W-1:0] world_north;
        logic signed [WORLD_W-1:0] world_up;
        logic                      clipped;
    } result_t;

    typedef logic [TERM_W-1:0] term_t;
    typedef term_t [8:0] rot_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] roll;
        logic [ANGLE_W-1:0] pitch;
        logic [ANGLE_W-1:0] yaw;
    } angles_t;

    typedef struct packed {
        logic signed [OFFSET_W-1:0] east;
        logic signed [OFFSET_W-1:0] north;
        logic signed [OFFSET_W-1:0] up;
    } offsets_t;

    typedef struct packed {
        logic       neg;
        logic [2:0] fa;
        logic [2:0] fb;
        logic [2:0] fc;
    } term_op_t;

    // Two product recipes per matrix term, row-major
    function automatic term_op_t term_op(input logic [4:0] idx);
        term_op_t op;
        op = '{1'b0, F_ZERO, F_ZERO, F_ZERO};
        case (idx)
            5'd0:  op = '{1'b0, F_CY, F_CP, F_ONE};
            5'd2:  op = '{1'b0, F_CY, F_SP, F_SR};
            5'd3:  op = '{1'b1, F_SY, F_CR, F_ONE};
            5'd4:  op = '{1'b0, F_CY, F_SP, F_CR};
            5'd5:  op = '{1'b0, F_SY, F_SR, F_ONE};
            5'd6:  op = '{1'b0, F_SY, F_CP, F_ONE};
            5'd8:  op = '{1'b0, F_SY, F_SP, F_SR};
            5'd9:  op = '{1'b0, F_CY, F_CR, F_ONE};
            5'd10: op = '{1'b0, F_SY, F_SP, F_CR};
            5'd11: op = '{1'b1, F_CY, F_SR, F_ONE};
            5'd12: op = '{1'b1, F_SP, F_ONE, F_ONE};
            5'd14: op = '{1'b0, F_CP, F_SR, F_ONE};
            5'd16: op = '{1'b0, F_CP, F_CR, F_ONE};
            default: op = '{1'b0, F_ZERO, F_ZERO, F_ZERO};
        endcase
        return op;
    endfunction

    // Taylor series divisors (2i)(2i+1)
    function automatic longint unsigned taylor_div(input int i);
        longint unsigned d;
        case (i)
            1: d = 64'd6;
            2: d = 64'd20;
            3: d = 64'd42;
            4: d = 64'd72;
            5: d = 64'd110;
            6: d = 64'd156;
            7: d = 64'd210;
            default: d = 64'd272;
        endcase
        return d;
    endfunction

    // Unsigned quotient by shift and subtract; evaluated at elaboration only
    function automatic longint unsigned udiv(input longint unsigned num,
                                             input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = 64'd0;
        rem = 64'd0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            quo = quo << 1;
            if (rem >= den)
            begin
                rem = rem - den;
                quo = quo | 64'd1;
            end
        end
        return quo;
    endfunction

    // Sine table entry k of 2^tb per turn, Q1.17; evaluated at elaboration
    function automatic logic signed [TERM_W-1:0] sine_entry(input int unsigned k,
                                                            input int unsigned tb);
        longint unsigned n;
        longint unsigned kk;
        longint unsigned quad;
        longint unsigned r;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint          s;
        logic signed [TERM_W-1:0] mag;
        n    = 64'd1 << tb;
        kk   = longint'(k) & (n - 64'd1);
        quad = kk >> (tb - 2);
        r    = kk & ((n >> 2) - 64'd1);
        x    = (r * 64'd6746518852) >> tb;
        if (quad[0])
            x = 64'd1686629713 - x;
        x2 = (x * x) >> 30;
        s  = longint'(x);
        t  = x;
        for (int i = 1; i <= 8; i++)
        begin
            t = udiv((t * x2) >> 30, taylor_div(i));
            if (i % 2 == 1)
                s = s - longint'(t);
            else
                s = s + longint'(t);
        end
        if (s < 0)
            s = 0;
        s = (s + 4096) >>> 13;
        if (s > 131071)
            s = 131071;
        mag = TERM_W'(s);
        return quad[1] ? -mag : mag;
    endfunction

endpackage

`default_nettype wire

### hdl/bwpt_front.sv
// ============================================================================
// bwpt_front
// Input side: accepts points, drops the origin point and queues the rest in
// a two-entry queue for the datapath.
// ============================================================================
`default_nettype none

module bwpt_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire bwpt_pkg::point_t in_data,
    input  wire logic            hold,
    output logic                 head_valid,
    output bwpt_pkg::point_t     head_data,
    input  wire logic            pop
);
    import bwpt_pkg::*;

    point_t     q_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       is_origin;
    logic       push;
    logic       do_pop;

    // Classify and accept
    assign is_origin  = (in_data.body_x == '0) && (in_data.body_y == '0)
                        && (in_data.body_z == '0);
    assign in_ready   = !hold && (cnt_reg != 2'd2);
    assign push       = in_valid && in_ready && !is_origin;
    assign head_valid = (cnt_reg != 2'd0);
    assign head_data  = q_reg[rp_reg];
    assign do_pop     = pop && head_valid;

    // Advance pointers and fill count
    always_comb
    begin
        wp_next  = push ? !wp_reg : wp_reg;
        rp_next  = do_pop ? !rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Hold queue entries
    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wp_reg] <= in_data;
    end

endmodule

`default_nettype wire

### hdl/bwpt_matrix.sv
// ============================================================================
// bwpt_matrix
// Rebuilds the nine rotation terms after a configuration write: six sine
// table reads, then eighteen triple products, each from three multiplies.
// ============================================================================
`default_nettype none

module bwpt_matrix #(
    parameter int TRIG_TABLE_BITS = bwpt_pkg::TRIG_BITS
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire bwpt_pkg::angles_t angles,
    output logic                  busy,
    output bwpt_pkg::rot_t        rot
);
    import bwpt_pkg::*;

    localparam int TB = TRIG_TABLE_BITS;
    localparam int N  = 1 << TB;
    localparam logic [TB-1:0] QUARTER = TB'(N / 4);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_TERM = 2'd2;

    localparam logic signed [FACT_W-1:0] ONE_F = 19'sd131072;
    localparam logic signed [57:0]       RND34 = 58'sd8589934592;

    logic signed [TERM_W-1:0] rom [N];

    logic [1:0]               state_reg, state_next;
    logic [2:0]               cnt_reg, cnt_next;
    logic [1:0]               ph_reg, ph_next;
    logic [4:0]               tix_reg, tix_next;
    logic [TB-1:0]            addr_reg, addr_next;
    logic signed [TERM_W-1:0] rom_q_reg;
    logic signed [TERM_W-1:0] fac_reg [6];
    logic signed [37:0]       p1_reg;
    logic signed [38:0]       lo_reg;
    logic signed [37:0]       hi_reg;
    logic signed [56:0]       acc_reg, acc_next;
    rot_t                     rot_reg, rot_next;

    term_op_t                 op;
    logic signed [FACT_W-1:0] fa, fb, fc;
    logic signed [19:0]       lo_a;
    logic signed [18:0]       hi_a;
    logic signed [56:0]       val;
    logic signed [57:0]       rr;
    logic signed [23:0]       q;
    logic [ANGLE_W-1:0]       ang;
    logic [TB-1:0]            sin_idx;
    logic [2:0]               fidx;

    // Build the sine table at elaboration
    for (genvar k = 0; k < N; k++)
    begin : g_rom
        localparam logic signed [TERM_W-1:0] V = sine_entry(k, TB);
        assign rom[k] = V;
    end

    function automatic logic signed [FACT_W-1:0] fsel(input logic [2:0] code,
        input logic signed [TERM_W-1:0] sr, input logic signed [TERM_W-1:0] cr,
        input logic signed [TERM_W-1:0] sp, input logic signed [TERM_W-1:0] cp,
        input logic signed [TERM_W-1:0] sy, input logic signed [TERM_W-1:0] cy);
        logic signed [FACT_W-1:0] f;
        case (code)
            F_SR:    f = FACT_W'(sr);
            F_CR:    f = FACT_W'(cr);
            F_SP:    f = FACT_W'(sp);
            F_CP:    f = FACT_W'(cp);
            F_SY:    f = FACT_W'(sy);
            F_CY:    f = FACT_W'(cy);
            F_ONE:   f = ONE_F;
            default: f = '0;
        endcase
        return f;
    endfunction

    assign busy = (state_reg != S_IDLE);
    assign rot  = rot_reg;

    // Select operands
    always_comb
    begin
        op   = term_op(tix_reg);
        fa   = fsel(op.fa, fac_reg[0], fac_reg[1], fac_reg[2], fac_reg[3],
                    fac_reg[4], fac_reg[5]);
        fb   = fsel(op.fb, fac_reg[0], fac_reg[1], fac_reg[2], fac_reg[3],
                    fac_reg[4], fac_reg[5]);
        fc   = fsel(op.fc, fac_reg[0], fac_reg[1], fac_reg[2], fac_reg[3],
                    fac_reg[4], fac_reg[5]);
        lo_a = {1'b0, p1_reg[18:0]};
        hi_a = p1_reg[37:19];
        val  = (57'(hi_reg) <<< 19) + 57'(lo_reg);
        case (cnt_reg[2:1])
            2'd0:    ang = angles.roll;
            2'd1:    ang = angles.pitch;
            default: ang = angles.yaw;
        endcase
        sin_idx = ang[ANGLE_W-1 -: TB];
        fidx    = cnt_reg - 3'd2;
    end

    // Sequence table reads and term products
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ph_next    = ph_reg;
        tix_next   = tix_reg;
        addr_next  = addr_reg;
        acc_next   = acc_reg;
        rot_next   = rot_reg;
        rr         = '0;
        q          = '0;
        case (state_reg)
            S_LOOK:
            begin
                addr_next = cnt_reg[0] ? sin_idx + QUARTER : sin_idx;
                cnt_next  = cnt_reg + 3'd1;
                if (cnt_reg == 3'd7)
                begin
                    state_next = S_TERM;
                    ph_next    = 2'd0;
                    tix_next   = 5'd0;
                end
            end
            S_TERM:
            begin
                ph_next = ph_reg + 2'd1;
                if (ph_reg == 2'd3)
                begin
                    acc_next = (tix_reg[0] ? acc_reg : 57'sd0)
                               + (op.neg ? -val : val);
                    if (tix_reg[0])
                    begin
                        rr = 58'(acc_next) + RND34;
                        q  = rr[57:34];
                        if (q > 24'(Q17_MAX))
                            rot_next[tix_reg[4:1]] = Q17_MAX;
                        else if (q < 24'(Q17_MIN))
                            rot_next[tix_reg[4:1]] = Q17_MIN;
                        else
                            rot_next[tix_reg[4:1]] = q[TERM_W-1:0];
                    end
                    tix_next = tix_reg + 5'd1;
                    if (tix_reg == 5'd17)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (start)
        begin
            state_next = S_LOOK;
            cnt_next   = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= 3'd0;
            ph_reg    <= 2'd0;
            tix_reg   <= 5'd0;
            for (int i = 0; i < 9; i++)
                rot_reg[i] <= (i % 4 == 0) ? Q17_MAX : '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ph_reg    <= ph_next;
            tix_reg   <= tix_next;
            rot_reg   <= rot_next;
        end
    end

    // Table read, factor capture and product stages
    always_ff @(posedge clk)
    begin
        addr_reg  <= addr_next;
        rom_q_reg <= rom[addr_reg];
        acc_reg   <= acc_next;
        if (state_reg == S_LOOK && cnt_reg >= 3'd2)
            fac_reg[fidx] <= rom_q_reg;
        if (state_reg == S_TERM)
        begin
            if (ph_reg == 2'd0)
                p1_reg <= fa * fb;
            if (ph_reg == 2'd1)
                lo_reg <= lo_a * fc;
            if (ph_reg == 2'd2)
                hi_reg <= hi_a * fc;
        end
    end

endmodule

`default_nettype wire

### hdl/bwpt_back.sv
// ============================================================================
// bwpt_back
// Datapath: nine products, row sums, rounding, offset and saturation in a
// three-stage pipeline that ends in the output register.
// ============================================================================
`default_nettype none

module bwpt_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              head_valid,
    input  wire bwpt_pkg::point_t  head_data,
    output logic                   pop,
    input  wire bwpt_pkg::rot_t    rot,
    input  wire bwpt_pkg::offsets_t offsets,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output bwpt_pkg::result_t      out_data
);
    import bwpt_pkg::*;

    localparam int PW = TERM_W + COORD_W;
    localparam int SW = PW + 2;
    localparam int HW = SW - 16;
    localparam int TW = ((HW > OFFSET_W) ? HW : OFFSET_W) + 1;

    localparam logic signed [SW:0]   RND17  = (SW + 1)'(65536);
    localparam logic signed [TW-1:0] W_MAX  = TW'(64'sd2147483647);
    localparam logic signed [TW-1:0] W_MIN  = TW'(-64'sd2147483648);

    logic signed [PW-1:0] prod_reg [9];
    logic signed [SW-1:0] sum_reg [3];
    logic                 v1_reg, v2_reg, ov_reg;
    result_t              out_reg, out_next;
    logic                 en;

    logic signed [COORD_W-1:0]  crd [3];
    logic signed [OFFSET_W-1:0] off [3];
    logic signed [SW:0]         rnd [3];
    logic signed [HW-1:0]       sh [3];
    logic signed [TW-1:0]       wv [3];
    logic signed [WORLD_W-1:0]  res [3];
    logic                       clip [3];

    assign en        = !ov_reg || out_ready;
    assign pop       = head_valid && en;
    assign out_valid = ov_reg;
    assign out_data  = out_reg;

    // Round, offset and saturate each row
    always_comb
    begin
        crd[0] = head_data.body_x;
        crd[1] = head_data.body_y;
        crd[2] = head_data.body_z;
        off[0] = offsets.east;
        off[1] = offsets.north;
        off[2] = offsets.up;
        for (int r = 0; r < 3; r++)
        begin
            rnd[r]  = (SW + 1)'(sum_reg[r]) + RND17;
            sh[r]   = rnd[r][SW:17];
            wv[r]   = TW'(sh[r]) + TW'(off[r]);
            clip[r] = (wv[r] > W_MAX) || (wv[r] < W_MIN);
            if (wv[r] > W_MAX)
                res[r] = wv[r] > W_MAX ? W_MAX[WORLD_W-1:0] : '0;
            else if (wv[r] < W_MIN)
                res[r] = W_MIN[WORLD_W-1:0];
            else
                res[r] = wv[r][WORLD_W-1:0];
        end
        out_next.world_east  = res[0];
        out_next.world_north = res[1];
        out_next.world_up    = res[2];
        out_next.clipped     = clip[0] || clip[1] || clip[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= head_valid;
            v2_reg <= v1_reg;
            ov_reg <= v2_reg;
        end
    end

    // Advance the payload stages together
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                    prod_reg[3 * r + c] <= $signed(rot[3 * r + c]) * crd[c];
            end
            for (int r = 0; r < 3; r++)
                sum_reg[r] <= SW'(prod_reg[3 * r]) + SW'(prod_reg[3 * r + 1])
                              + SW'(prod_reg[3 * r + 2]);
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

### hdl/body_to_world_point_transform_top.sv
// ============================================================================
// body_to_world_point_transform_top
// Rotates body-frame points by the Z-Y-X Euler matrix and adds the vehicle
// position, giving saturated east-north-up points.
// ============================================================================
// Usage:
//   in_*  : one body-frame point per transaction; an all-zero point is
//           consumed and gives no result.
//   out_* : one world point per non-origin input, in order, with a clipped
//           flag when any coordinate saturated.
//   cfg_* : register index and data; index 0..5 writes roll, pitch, yaw,
//           east, north, up; other indexes are ignored.
// Throughput is one point per cycle unless a rebuild or an output stall holds
// the flow; a point passes the queue entry and three datapath stages.
// A write to a register rebuilds the matrix (six table reads, then eighteen
// triple products, each from three multiplies); in_ready is low meanwhile.
// cfg_ready is always high.
// Reset clears the registers to zero and the matrix to identity. When the
// receiver stalls, the output register holds, the pipeline freezes and the
// two-entry queue fills before in_ready drops.
// ============================================================================
`default_nettype none

module body_to_world_point_transform_top #(
    parameter int TRIG_TABLE_BITS = bwpt_pkg::TRIG_BITS
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire bwpt_pkg::point_t                   in_data,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output bwpt_pkg::result_t                       out_data,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [bwpt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bwpt_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import bwpt_pkg::*;

    angles_t  ang_reg, ang_next;
    offsets_t off_reg, off_next;
    logic     cfg_wr;
    logic     start;
    logic     busy;
    rot_t     rot;
    logic     head_valid;
    point_t   head_data;
    logic     pop;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign start     = cfg_wr && (cfg_index <= REG_UP);

    // Decode register writes
    always_comb
    begin
        ang_next = ang_reg;
        off_next = off_reg;
        if (cfg_wr)
        begin
            case (cfg_index)
                REG_ROLL:  ang_next.roll  = cfg_data[ANGLE_W-1:0];
                REG_PITCH: ang_next.pitch = cfg_data[ANGLE_W-1:0];
                REG_YAW:   ang_next.yaw   = cfg_data[ANGLE_W-1:0];
                REG_EAST:  off_next.east  = cfg_data;
                REG_NORTH: off_next.north = cfg_data;
                REG_UP:    off_next.up    = cfg_data;
                default:   ang_next = ang_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ang_reg <= '0;
            off_reg <= '0;
        end
        else
        begin
            ang_reg <= ang_next;
            off_reg <= off_next;
        end
    end

    bwpt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .hold       (busy),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop)
    );

    bwpt_matrix #(
        .TRIG_TABLE_BITS (TRIG_TABLE_BITS)
    ) u_matrix (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .angles (ang_reg),
        .busy   (busy),
        .rot    (rot)
    );

    bwpt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .rot        (rot),
        .offsets    (off_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    // No point enters while the matrix is being rebuilt
    a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !in_ready)
        else $error("point accepted during matrix rebuild");

    // A valid register write starts a rebuild
    a_write_rebuilds: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy)
        else $error("register write did not start a rebuild");

    // A clipped result carries a saturated coordinate
    a_clip_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.clipped) |->
            (out_data.world_east == 32'sh7FFFFFFF || out_data.world_east == 32'sh80000000
             || out_data.world_north == 32'sh7FFFFFFF
             || out_data.world_north == 32'sh80000000
             || out_data.world_up == 32'sh7FFFFFFF || out_data.world_up == 32'sh80000000))
        else $error("clipped flag without a saturated coordinate");

endmodule

`default_nettype wire
